### hdl/rgcm_pkg.sv
// Package for the range-gated confusion metrics block.
// Holds field widths, register indexes, the counter ceiling, the sequencer types
// and the divider request and response structs. No dependencies.
package rgcm_pkg;

  localparam int unsigned DIST_W = 18;
  localparam int unsigned CNT_W = 20;
  localparam int unsigned Q_W = 17;
  localparam int unsigned DEN_W = 22;
  localparam int unsigned REM_W = DEN_W + 1;
  localparam int unsigned DIV_STEPS = Q_W;
  localparam int unsigned STEP_W = 5;
  localparam int unsigned NUM_LEVELS = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 18;

  localparam int unsigned MAX_POINTS = 1048576;
  localparam logic [CNT_W-1:0] CNT_FIELD_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_CAP =
      ((MAX_POINTS - 1) < 32'(CNT_FIELD_MAX)) ? CNT_W'(MAX_POINTS - 1) : CNT_FIELD_MAX;

  localparam logic [Q_W-1:0] ONE_Q16 = Q_W'(65536);

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_HI = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_ENABLE = 2'd2;

  localparam logic [DIST_W-1:0] RANGE_LO_RESET = '0;
  localparam logic [DIST_W-1:0] RANGE_HI_RESET = '1;
  localparam logic [NUM_LEVELS-1:0] LEVEL_ENABLE_RESET = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    RATIO_IOU,
    RATIO_PRECISION,
    RATIO_RECALL
  } ratio_t;

  typedef struct packed {
    logic start;
    logic [CNT_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [Q_W-1:0] quotient;
  } div_rsp_t;

endpackage

### hdl/range_gated_confusion_metrics_core.sv
// Top level of the range-gated confusion metrics block.
// Counts per-level confusion statistics and reports IoU, precision and recall per frame.
// Depends on rgcm_pkg and rgcm_div.
//
// The input channel (in_valid, in_stall) carries one labelled point per transfer.
// A point whose distance lies within [range_lo, range_hi] updates the true and
// false positive and negative counters of the point, cluster and object levels;
// every point updates the total count. Counters saturate.
// Ordinary points stream at one per cycle while in_stall is low.
// A point marked end_of_frame starts the report: for each level enabled in
// level_enable, in the order point, cluster, object, three quotients are formed
// one after another on one shared restoring divider, and the result is then
// offered on the output channel (out_valid, out_stall). in_stall stays high
// until the last result of the frame has been transferred. While the receiver
// stalls, the result holds and the block waits. last_of_run marks the final
// result; the counters then clear. With no level enabled the frame end reports
// nothing and only clears. Configuration writes (cfg_write, cfg_index, cfg_data)
// take effect at once and are expected while the block is idle. Reset restores
// the register defaults, clears all counters and drops out_valid.
module range_gated_confusion_metrics_core (
  input  logic clk,
  input  logic rst,

  input  logic cfg_write,
  input  logic [rgcm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rgcm_pkg::CFG_DATA_W-1:0] cfg_data,

  input  logic in_valid,
  output logic in_stall,
  input  logic [rgcm_pkg::DIST_W-1:0] distance,
  input  logic point_flag,
  input  logic cluster_flag,
  input  logic object_flag,
  input  logic truth_dynamic,
  input  logic end_of_frame,

  output logic out_valid,
  input  logic out_stall,
  output logic [1:0] level,
  output logic [rgcm_pkg::Q_W-1:0] iou,
  output logic [rgcm_pkg::Q_W-1:0] precision,
  output logic [rgcm_pkg::Q_W-1:0] recall,
  output logic [rgcm_pkg::CNT_W-1:0] true_pos,
  output logic [rgcm_pkg::CNT_W-1:0] true_neg,
  output logic [rgcm_pkg::CNT_W-1:0] false_pos,
  output logic [rgcm_pkg::CNT_W-1:0] false_neg,
  output logic [rgcm_pkg::CNT_W-1:0] windowed_points,
  output logic [rgcm_pkg::CNT_W-1:0] total_points,
  output logic last_of_run
);

  localparam int unsigned NL = rgcm_pkg::NUM_LEVELS;
  localparam int unsigned CW = rgcm_pkg::CNT_W;

  logic [rgcm_pkg::DIST_W-1:0] range_lo;
  logic [rgcm_pkg::DIST_W-1:0] range_hi;
  logic [NL-1:0] level_enable;

  logic [CW-1:0] tp_cnt [NL];
  logic [CW-1:0] fp_cnt [NL];
  logic [CW-1:0] tn_cnt [NL];
  logic [CW-1:0] fn_cnt [NL];
  logic [CW-1:0] eval_cnt;
  logic [CW-1:0] total_cnt;

  rgcm_pkg::state_t state;
  rgcm_pkg::state_t state_next;
  rgcm_pkg::ratio_t sel;
  logic div_pending;
  logic [1:0] lvl;
  logic [rgcm_pkg::Q_W-1:0] iou_q;
  logic [rgcm_pkg::Q_W-1:0] prec_q;
  logic [rgcm_pkg::Q_W-1:0] rec_q;

  rgcm_pkg::div_req_t div_req;
  rgcm_pkg::div_rsp_t div_rsp;

  logic in_take;
  logic out_take;
  logic in_window;
  logic [NL-1:0] pred;
  logic [NL-1:0] later_mask;
  logic [NL-1:0] remaining;
  logic is_last;
  logic clear_all;
  logic [CW-1:0] cur_tp;
  logic [CW-1:0] cur_fp;
  logic [CW-1:0] cur_fn;

  function automatic logic [1:0] lowest_level(input logic [NL-1:0] mask);
    logic [1:0] idx;
    idx = 2'd0;
    for (int i = NL - 1; i >= 0; i--) begin
      if (mask[i]) begin
        idx = 2'(i);
      end
    end
    return idx;
  endfunction

  rgcm_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  always_comb begin
    pred = {object_flag, cluster_flag, point_flag};
    in_window = (distance >= range_lo) && (distance <= range_hi);
    in_take = in_valid && !in_stall;
    out_take = out_valid && !out_stall;
    unique case (lvl)
      2'd0: later_mask = 3'b110;
      2'd1: later_mask = 3'b100;
      default: later_mask = 3'b000;
    endcase
    remaining = level_enable & later_mask;
    is_last = (remaining == '0);
    clear_all = (out_take && is_last) ||
                (in_take && end_of_frame && (level_enable == '0));
    cur_tp = tp_cnt[lvl];
    cur_fp = fp_cnt[lvl];
    cur_fn = fn_cnt[lvl];
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      rgcm_pkg::ST_IDLE: begin
        if (in_take && end_of_frame && (level_enable != '0)) begin
          state_next = rgcm_pkg::ST_DIV;
        end
      end
      rgcm_pkg::ST_DIV: begin
        if (div_rsp.done && (sel == rgcm_pkg::RATIO_RECALL)) begin
          state_next = rgcm_pkg::ST_OUT;
        end
      end
      rgcm_pkg::ST_OUT: begin
        if (out_take) begin
          state_next = is_last ? rgcm_pkg::ST_IDLE : rgcm_pkg::ST_DIV;
        end
      end
      default: state_next = rgcm_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall = (state != rgcm_pkg::ST_IDLE);
    out_valid = (state == rgcm_pkg::ST_OUT);
    div_req.start = (state == rgcm_pkg::ST_DIV) && div_pending;
    div_req.num = cur_tp;
    unique case (sel)
      rgcm_pkg::RATIO_IOU: begin
        div_req.den = rgcm_pkg::DEN_W'(cur_tp) + rgcm_pkg::DEN_W'(cur_fp) +
                      rgcm_pkg::DEN_W'(cur_fn);
      end
      rgcm_pkg::RATIO_PRECISION: begin
        div_req.den = rgcm_pkg::DEN_W'(cur_tp) + rgcm_pkg::DEN_W'(cur_fp);
      end
      rgcm_pkg::RATIO_RECALL: begin
        div_req.den = rgcm_pkg::DEN_W'(cur_tp) + rgcm_pkg::DEN_W'(cur_fn);
      end
      default: div_req.den = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      range_lo <= rgcm_pkg::RANGE_LO_RESET;
      range_hi <= rgcm_pkg::RANGE_HI_RESET;
      level_enable <= rgcm_pkg::LEVEL_ENABLE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rgcm_pkg::REG_RANGE_LO: range_lo <= cfg_data[rgcm_pkg::DIST_W-1:0];
        rgcm_pkg::REG_RANGE_HI: range_hi <= cfg_data[rgcm_pkg::DIST_W-1:0];
        rgcm_pkg::REG_LEVEL_ENABLE: level_enable <= cfg_data[NL-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rgcm_pkg::ST_IDLE;
      sel <= rgcm_pkg::RATIO_IOU;
      div_pending <= 1'b0;
      lvl <= 2'd0;
    end else begin
      state <= state_next;
      if (state == rgcm_pkg::ST_IDLE) begin
        lvl <= lowest_level(level_enable);
        sel <= rgcm_pkg::RATIO_IOU;
        div_pending <= 1'b1;
      end else if (state == rgcm_pkg::ST_DIV) begin
        if (div_req.start) begin
          div_pending <= 1'b0;
        end else if (div_rsp.done) begin
          div_pending <= 1'b1;
          unique case (sel)
            rgcm_pkg::RATIO_IOU: sel <= rgcm_pkg::RATIO_PRECISION;
            rgcm_pkg::RATIO_PRECISION: sel <= rgcm_pkg::RATIO_RECALL;
            default: sel <= rgcm_pkg::RATIO_IOU;
          endcase
        end
      end else if (out_take) begin
        lvl <= lowest_level(remaining);
        sel <= rgcm_pkg::RATIO_IOU;
        div_pending <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == rgcm_pkg::ST_DIV) && div_rsp.done) begin
      unique case (sel)
        rgcm_pkg::RATIO_IOU: iou_q <= div_rsp.quotient;
        rgcm_pkg::RATIO_PRECISION: prec_q <= div_rsp.quotient;
        default: rec_q <= div_rsp.quotient;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      for (int i = 0; i < NL; i++) begin
        tp_cnt[i] <= '0;
        fp_cnt[i] <= '0;
        tn_cnt[i] <= '0;
        fn_cnt[i] <= '0;
      end
      eval_cnt <= '0;
      total_cnt <= '0;
    end else if (in_take) begin
      if (total_cnt < rgcm_pkg::CNT_CAP) begin
        total_cnt <= total_cnt + 1'b1;
      end
      if (in_window) begin
        if (eval_cnt < rgcm_pkg::CNT_CAP) begin
          eval_cnt <= eval_cnt + 1'b1;
        end
        for (int i = 0; i < NL; i++) begin
          if (pred[i] && truth_dynamic) begin
            if (tp_cnt[i] < rgcm_pkg::CNT_CAP) tp_cnt[i] <= tp_cnt[i] + 1'b1;
          end else if (pred[i]) begin
            if (fp_cnt[i] < rgcm_pkg::CNT_CAP) fp_cnt[i] <= fp_cnt[i] + 1'b1;
          end else if (!truth_dynamic) begin
            if (tn_cnt[i] < rgcm_pkg::CNT_CAP) tn_cnt[i] <= tn_cnt[i] + 1'b1;
          end else begin
            if (fn_cnt[i] < rgcm_pkg::CNT_CAP) fn_cnt[i] <= fn_cnt[i] + 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    level = lvl;
    iou = iou_q;
    precision = prec_q;
    recall = rec_q;
    true_pos = cur_tp;
    true_neg = tn_cnt[lvl];
    false_pos = cur_fp;
    false_neg = cur_fn;
    windowed_points = eval_cnt;
    total_points = total_cnt;
    last_of_run = is_last;
  end

endmodule

### hdl/rgcm_div.sv
// Shared restoring divider: floor(num * 65536 / den) for num <= den, one bit a cycle.
// A zero divisor gives 1.0 in Q1.16. Depends on rgcm_pkg.
module rgcm_div (
  input  logic clk,
  input  logic rst,
  input  rgcm_pkg::div_req_t req,
  output rgcm_pkg::div_rsp_t rsp
);

  logic busy;
  logic done;
  logic [rgcm_pkg::STEP_W-1:0] step;
  logic [rgcm_pkg::REM_W-1:0] rem;
  logic [rgcm_pkg::DEN_W-1:0] den;
  logic den_zero;
  logic [rgcm_pkg::Q_W-1:0] quo;

  logic [rgcm_pkg::REM_W-1:0] shifted;
  logic [rgcm_pkg::REM_W-1:0] den_ext;
  logic fits;

  // The first step compares without a shift, since the quotient can reach 1.0.
  always_comb begin
    den_ext = {1'b0, den};
    shifted = (step == '0) ? rem : {rem[rgcm_pkg::REM_W-2:0], 1'b0};
    fits = (shifted >= den_ext);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == rgcm_pkg::STEP_W'(rgcm_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= rgcm_pkg::REM_W'(req.num);
      den <= req.den;
      den_zero <= (req.den == '0);
      quo <= '0;
    end else if (busy) begin
      rem <= fits ? (shifted - den_ext) : shifted;
      quo <= {quo[rgcm_pkg::Q_W-2:0], fits};
    end
  end

  always_comb begin
    rsp.done = done;
    rsp.quotient = den_zero ? rgcm_pkg::ONE_Q16 : quo;
  end

endmodule
